// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication, off while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// condition that must hold in the cycle after reset
`define ASSERT_AFTER_RESET(lbl, clk, rst, cons) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("post-reset check failed");

`endif

// ===== rtl/mke_pkg.sv =====
// shared types, constants, symbol table and microcode for the morse keying encoder
package mke_pkg;

   localparam int CHAR_W     = 8;
   localparam int UNIT_W     = 16;
   localparam int DUR_W      = 18;
   localparam int UNITS_W    = 3;
   localparam int PROD_W     = UNITS_W + UNIT_W;
   localparam int PAT_W      = 5;
   localparam int LEN_W      = 3;
   localparam int SYM_COUNT  = 36;
   localparam int SYM_IDX_W  = 6;
   localparam int STEP_W     = 2;
   localparam int APB_ADDR_W = 2;
   localparam int APB_DATA_W = 32;

   localparam logic [UNIT_W-1:0]     UNIT_MS_RESET = 16'd100;
   localparam logic [APB_ADDR_W-1:0] ADDR_UNIT_MS  = 2'd0;

   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [SYM_IDX_W-1:0] DIGIT_BASE = 6'd26;

   localparam logic [UNITS_W-1:0] UNITS_DOT  = 3'd1;
   localparam logic [UNITS_W-1:0] UNITS_DASH = 3'd3;
   localparam logic [UNITS_W-1:0] UNITS_LONG = 3'd4;

   // microcode addresses
   typedef logic [STEP_W-1:0] step_type;
   localparam step_type STEP_IDLE  = 2'd0;
   localparam step_type STEP_MARK  = 2'd1;
   localparam step_type STEP_GAP   = 2'd2;
   localparam step_type STEP_SPACE = 2'd3;

   typedef enum logic [1:0] {
      COND_ALWAYS,
      COND_MORE,
      COND_DISPATCH
   } cond_type;

   typedef enum logic [1:0] {
      UNITS_ELEM,
      UNITS_GAP,
      UNITS_FOUR
   } units_sel_type;

   typedef enum logic [1:0] {
      FIN_NONE,
      FIN_ELEM,
      FIN_ALWAYS
   } fin_sel_type;

   typedef struct packed {
      logic          wait_item;
      logic          emit;
      logic          key;
      units_sel_type units;
      fin_sel_type   fin;
      logic          shift;
      cond_type      cond;
      step_type      tgt;
      step_type      alt;
   } ucode_type;

   typedef struct packed {
      logic              load;
      logic [LEN_W-1:0]  len;
      logic [PAT_W-1:0]  pat;
      logic              emit;
      logic              key;
      units_sel_type     units;
      fin_sel_type       fin;
      logic              shift;
   } dp_ctrl_type;

   typedef struct packed {
      logic slot_free;
      logic elem_more;
   } dp_stat_type;

   typedef struct packed {
      logic              is_space;
      logic              is_sym;
      logic [LEN_W-1:0]  len;
      logic [PAT_W-1:0]  pat;
   } sym_type;

   // {length, pattern}; pattern bit 0 is the first element, 1 = dash
   localparam logic [LEN_W+PAT_W-1:0] SYM_ROM [0:SYM_COUNT-1] = '{
      {3'd2, 5'b00010}, {3'd4, 5'b00001}, {3'd4, 5'b00101}, {3'd3, 5'b00001},
      {3'd1, 5'b00000}, {3'd4, 5'b00100}, {3'd3, 5'b00011}, {3'd4, 5'b00000},
      {3'd2, 5'b00000}, {3'd4, 5'b01110}, {3'd3, 5'b00101}, {3'd4, 5'b00010},
      {3'd2, 5'b00011}, {3'd2, 5'b00001}, {3'd3, 5'b00111}, {3'd4, 5'b00110},
      {3'd4, 5'b01011}, {3'd3, 5'b00010}, {3'd3, 5'b00000}, {3'd1, 5'b00001},
      {3'd3, 5'b00100}, {3'd4, 5'b01000}, {3'd3, 5'b00110}, {3'd4, 5'b01001},
      {3'd4, 5'b01101}, {3'd4, 5'b00011},
      {3'd5, 5'b11111}, {3'd5, 5'b11110}, {3'd5, 5'b11100}, {3'd5, 5'b11000},
      {3'd5, 5'b10000}, {3'd5, 5'b00000}, {3'd5, 5'b00001}, {3'd5, 5'b00011},
      {3'd5, 5'b00111}, {3'd5, 5'b01111}
   };

   function automatic sym_type sym_lookup(logic [CHAR_W-1:0] c);
      sym_type                 s;
      logic [SYM_IDX_W-1:0]    idx;
      logic [LEN_W+PAT_W-1:0]  entry;
      s     = '0;
      idx   = '0;
      if (c == CHAR_SPACE) begin
         s.is_space = 1'b1;
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         s.is_sym = 1'b1;
         idx      = SYM_IDX_W'(c - CHAR_UPPER_A);
      end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         s.is_sym = 1'b1;
         idx      = SYM_IDX_W'(c - CHAR_DIGIT_0) + DIGIT_BASE;
      end
      entry = SYM_ROM[idx];
      if (s.is_sym) begin
         s.len = entry[LEN_W+PAT_W-1:PAT_W];
         s.pat = entry[PAT_W-1:0];
      end
      return s;
   endfunction

   // control store: one word per step
   function automatic ucode_type ucode_fetch(step_type step);
      ucode_type w;
      w = '{wait_item: 1'b0, emit: 1'b0, key: 1'b0, units: UNITS_FOUR, fin: FIN_NONE,
            shift: 1'b0, cond: COND_ALWAYS, tgt: STEP_IDLE, alt: STEP_IDLE};
      case (step)
         STEP_IDLE: begin
            w.wait_item = 1'b1;
            w.cond      = COND_DISPATCH;
            w.tgt       = STEP_SPACE;
            w.alt       = STEP_MARK;
         end
         STEP_MARK: begin
            w.emit  = 1'b1;
            w.key   = 1'b1;
            w.units = UNITS_ELEM;
            w.cond  = COND_ALWAYS;
            w.tgt   = STEP_GAP;
         end
         STEP_GAP: begin
            w.emit  = 1'b1;
            w.units = UNITS_GAP;
            w.fin   = FIN_ELEM;
            w.shift = 1'b1;
            w.cond  = COND_MORE;
            w.tgt   = STEP_MARK;
            w.alt   = STEP_IDLE;
         end
         STEP_SPACE: begin
            w.emit  = 1'b1;
            w.units = UNITS_FOUR;
            w.fin   = FIN_ALWAYS;
            w.cond  = COND_ALWAYS;
            w.tgt   = STEP_IDLE;
         end
         default: begin
            w.cond = COND_ALWAYS;
            w.tgt  = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/mke_req_if.sv =====
// character item channel
interface mke_req_if;
   logic                        valid;
   logic                        ready;
   logic [mke_pkg::CHAR_W-1:0]  char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

// ===== rtl/mke_rsp_if.sv =====
// keying segment channel
interface mke_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       key_on;
   logic [mke_pkg::DUR_W-1:0]  duration_ms;
   logic                       last;

   modport source (output valid, output key_on, output duration_ms, output last, input ready);
   modport sink   (input valid, input key_on, input duration_ms, input last, output ready);
endinterface

// ===== rtl/mke_csr.sv =====
// apb register file holding the unit length
module mke_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mke_pkg::APB_ADDR_W-1:0]  paddr,
   input  logic [mke_pkg::APB_DATA_W-1:0]  pwdata,
   output logic [mke_pkg::APB_DATA_W-1:0]  prdata,
   output logic                            pready,
   output logic [mke_pkg::UNIT_W-1:0]      unit_ms
);

   logic [mke_pkg::UNIT_W-1:0] unit_ms_ff;
   logic [mke_pkg::UNIT_W-1:0] unit_ms_in;
   logic                       wr_unit;

   assign wr_unit = psel && penable && pwrite && (paddr == mke_pkg::ADDR_UNIT_MS);

   always_comb begin
      unit_ms_in = unit_ms_ff;
      if (wr_unit) begin
         unit_ms_in = pwdata[mke_pkg::UNIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ms_ff <= mke_pkg::UNIT_MS_RESET;
      end else begin
         unit_ms_ff <= unit_ms_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr == mke_pkg::ADDR_UNIT_MS) begin
         prdata = mke_pkg::APB_DATA_W'(unit_ms_ff);
      end
   end

   assign pready  = 1'b1;
   assign unit_ms = unit_ms_ff;

endmodule

// ===== rtl/mke_useq.sv =====
// microcode sequencer: step counter, control store fetch, branch logic
module mke_useq (
   input  logic                 clock,
   input  logic                 reset,
   mke_req_if.sink              req_chan,
   input  mke_pkg::dp_stat_type dp_stat,
   output mke_pkg::dp_ctrl_type dp_ctrl
);

   mke_pkg::step_type  step_ff;
   mke_pkg::step_type  step_in;
   mke_pkg::ucode_type word;
   mke_pkg::sym_type   sym;
   logic               accept;
   logic               go;

   assign word   = mke_pkg::ucode_fetch(step_ff);
   assign sym    = mke_pkg::sym_lookup(req_chan.char_code);
   assign req_chan.ready = word.wait_item;
   assign accept = req_chan.valid && word.wait_item;
   // an emitting step waits for room in the output register
   assign go     = !word.emit || dp_stat.slot_free;

   always_comb begin
      step_in = step_ff;
      case (word.cond)
         mke_pkg::COND_ALWAYS: begin
            if (go) begin
               step_in = word.tgt;
            end
         end
         mke_pkg::COND_MORE: begin
            if (go) begin
               step_in = dp_stat.elem_more ? word.tgt : word.alt;
            end
         end
         mke_pkg::COND_DISPATCH: begin
            // unsupported codes are taken and dropped
            if (accept && sym.is_space) begin
               step_in = word.tgt;
            end else if (accept && sym.is_sym) begin
               step_in = word.alt;
            end
         end
         default: begin
            step_in = mke_pkg::STEP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= mke_pkg::STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      dp_ctrl.load  = accept && sym.is_sym;
      dp_ctrl.len   = sym.len;
      dp_ctrl.pat   = sym.pat;
      dp_ctrl.emit  = word.emit && dp_stat.slot_free;
      dp_ctrl.key   = word.key;
      dp_ctrl.units = word.units;
      dp_ctrl.fin   = word.fin;
      dp_ctrl.shift = word.shift && dp_stat.slot_free;
   end

endmodule

// ===== rtl/mke_dp.sv =====
// symbol shifter, duration multiply and output register
module mke_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [mke_pkg::UNIT_W-1:0]  unit_ms,
   input  mke_pkg::dp_ctrl_type        dp_ctrl,
   output mke_pkg::dp_stat_type        dp_stat,
   mke_rsp_if.source                   rsp_chan
);

   logic [mke_pkg::PAT_W-1:0]   pat_ff;
   logic [mke_pkg::PAT_W-1:0]   pat_in;
   logic [mke_pkg::LEN_W-1:0]   left_ff;
   logic [mke_pkg::LEN_W-1:0]   left_in;
   logic                        valid_ff;
   logic                        valid_in;
   logic                        key_ff;
   logic [mke_pkg::DUR_W-1:0]   dur_ff;
   logic                        last_ff;
   logic                        elem_last;
   logic                        slot_free;
   logic                        fin;
   logic [mke_pkg::UNITS_W-1:0] units;
   logic [mke_pkg::PROD_W-1:0]  prod;

   assign elem_last = (left_ff == mke_pkg::LEN_W'(1));
   assign slot_free = !valid_ff || rsp_chan.ready;

   always_comb begin
      case (dp_ctrl.units)
         mke_pkg::UNITS_ELEM: units = pat_ff[0] ? mke_pkg::UNITS_DASH : mke_pkg::UNITS_DOT;
         mke_pkg::UNITS_GAP:  units = elem_last ? mke_pkg::UNITS_LONG : mke_pkg::UNITS_DOT;
         mke_pkg::UNITS_FOUR: units = mke_pkg::UNITS_LONG;
         default:             units = mke_pkg::UNITS_LONG;
      endcase
   end

   always_comb begin
      case (dp_ctrl.fin)
         mke_pkg::FIN_NONE:   fin = 1'b0;
         mke_pkg::FIN_ELEM:   fin = elem_last;
         mke_pkg::FIN_ALWAYS: fin = 1'b1;
         default:             fin = 1'b0;
      endcase
   end

   assign prod = mke_pkg::PROD_W'(units) * mke_pkg::PROD_W'(unit_ms);

   always_comb begin
      pat_in  = pat_ff;
      left_in = left_ff;
      if (dp_ctrl.load) begin
         pat_in  = dp_ctrl.pat;
         left_in = dp_ctrl.len;
      end else if (dp_ctrl.shift) begin
         pat_in  = pat_ff >> 1;
         left_in = left_ff - mke_pkg::LEN_W'(1);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (dp_ctrl.emit) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pat_ff  <= pat_in;
      left_ff <= left_in;
      if (dp_ctrl.emit) begin
         key_ff  <= dp_ctrl.key;
         dur_ff  <= prod[mke_pkg::DUR_W-1:0];
         last_ff <= fin;
      end
   end

   assign dp_stat.slot_free = slot_free;
   assign dp_stat.elem_more = !elem_last;

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.key_on      = key_ff;
   assign rsp_chan.duration_ms = dur_ff;
   assign rsp_chan.last        = last_ff;

endmodule

// ===== rtl/morse_keying_encoder.sv =====
// morse keying encoder top level: character items in, keying segments out
//
//  channel   direction  handshake             payload
//  req_chan  in         valid / ready         char_code[7:0]
//  rsp_chan  out        valid / ready         key_on, duration_ms[17:0], last
//  csr       in         apb write / read      unit_ms[15:0] at byte address 0
//
//  a letter or digit runs idle, then a mark and a gap step per element;
//  a space runs idle then space, any other code idle only; the sequencer
//  runs one control word per cycle unless an emitting step stalls, and
//  each segment uses the shared duration multiplier; a held result on
//  rsp_chan stalls the sequencer on its next emitting step; reset is
//  synchronous: sequencer returns to idle, output empties, unit_ms goes back to 100
module morse_keying_encoder (
   input  logic                            clock,
   input  logic                            reset,
   mke_req_if.sink                         req_chan,
   mke_rsp_if.source                       rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mke_pkg::APB_ADDR_W-1:0]  paddr,
   input  logic [mke_pkg::APB_DATA_W-1:0]  pwdata,
   output logic [mke_pkg::APB_DATA_W-1:0]  prdata,
   output logic                            pready
);

   // unit length in ms; to be changed only while idle, which the block does not enforce
   logic [mke_pkg::UNIT_W-1:0] unit_ms;

   // sequencer to datapath control and datapath status back
   mke_pkg::dp_ctrl_type dp_ctrl;
   mke_pkg::dp_stat_type dp_stat;

   // register file
   mke_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .unit_ms (unit_ms)
   );

   // microcode sequencer: idle/dispatch, mark, gap and space steps
   mke_useq u_useq (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .dp_stat  (dp_stat),
      .dp_ctrl  (dp_ctrl)
   );

   // element shifter, units times unit_ms, output register
   mke_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .unit_ms  (unit_ms),
      .dp_ctrl  (dp_ctrl),
      .dp_stat  (dp_stat),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== rtl/mke_checker.sv =====
// port-level checks on the morse keying encoder and their bind
`include "assert_macros.svh"

module mke_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_key_on,
   input logic [mke_pkg::DUR_W-1:0]  rsp_duration_ms,
   input logic                       rsp_last
);

   logic req_take;
   logic rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // output register empties on reset
   `ASSERT_AFTER_RESET(a_rsp_empty_after_reset, clock, reset, !rsp_valid)

   // a stalled item holds its payload
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_key_on) && $stable(rsp_duration_ms) && $stable(rsp_last))

   // while a character is mid-flight no new character is taken
   `ASSERT_IMPLY(a_busy_no_take, clock, reset, rsp_valid && !rsp_last && !req_take, !req_ready)

   // a keyed segment is never last and is always followed by an off segment
   `ASSERT_IMPLY(a_mark_not_last, clock, reset, rsp_valid && rsp_key_on, !rsp_last)
   `ASSERT_NEXT(a_mark_then_gap, clock, reset, rsp_take && rsp_key_on, !(rsp_take && rsp_key_on))

endmodule

bind morse_keying_encoder mke_checker u_mke_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_key_on      (rsp_chan.key_on),
   .rsp_duration_ms (rsp_chan.duration_ms),
   .rsp_last        (rsp_chan.last)
);
